@@ rtl/mpfa_pkg.sv @@
// ----------------------------------------------------------------------------
// Montgomery prime-field ALU package
// Shared widths, operation and register codes, state type and bundles.
// ----------------------------------------------------------------------------
package mpfa_pkg;

   localparam int HALF_W = 64;
   localparam int WORD_W = 2 * HALF_W;
   localparam int CNT_W  = $clog2(WORD_W);

   typedef enum logic [2:0] {
      OP_ADD       = 3'd0,
      OP_SUB       = 3'd1,
      OP_NEG       = 3'd2,
      OP_MUL       = 3'd3,
      OP_TO_MONT   = 3'd4,
      OP_FROM_MONT = 3'd5,
      OP_INVERSE   = 3'd6,
      OP_LEGENDRE  = 3'd7
   } op_type;

   typedef enum logic [2:0] {
      REG_MOD_LO  = 3'd0,
      REG_MOD_HI  = 3'd1,
      REG_INV_LO  = 3'd2,
      REG_INV_HI  = 3'd3,
      REG_ONE_LO  = 3'd4,
      REG_ONE_HI  = 3'd5,
      REG_RSQ_LO  = 3'd6,
      REG_RSQ_HI  = 3'd7
   } reg_idx_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PRE,
      ST_RED,
      ST_MT,
      ST_MM,
      ST_MP,
      ST_MD,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic [WORD_W-1:0] modulus;
      logic [WORD_W-1:0] modulus_inv;
      logic [WORD_W-1:0] r_mod_p;
      logic [WORD_W-1:0] r_squared;
   } cfg_type;

   typedef struct packed {
      logic busy;
      logic done;
   } mul_status_type;

endpackage

@@ rtl/mpfa_csr.sv @@
// ----------------------------------------------------------------------------
// Configuration registers
// Holds the modulus, its inverse, Montgomery one and R squared.
// ----------------------------------------------------------------------------
module mpfa_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [2:0]                   csr_index,
   input  logic [mpfa_pkg::HALF_W-1:0]  csr_data,
   output mpfa_pkg::cfg_type            cfg
);

   mpfa_pkg::cfg_type cfg_ff;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_valid) begin
         unique case (mpfa_pkg::reg_idx_type'(csr_index))
            mpfa_pkg::REG_MOD_LO: cfg_ff.modulus[mpfa_pkg::HALF_W-1:0] <= csr_data;
            mpfa_pkg::REG_MOD_HI: cfg_ff.modulus[mpfa_pkg::WORD_W-1:mpfa_pkg::HALF_W] <= csr_data;
            mpfa_pkg::REG_INV_LO: cfg_ff.modulus_inv[mpfa_pkg::HALF_W-1:0] <= csr_data;
            mpfa_pkg::REG_INV_HI:
               cfg_ff.modulus_inv[mpfa_pkg::WORD_W-1:mpfa_pkg::HALF_W] <= csr_data;
            mpfa_pkg::REG_ONE_LO: cfg_ff.r_mod_p[mpfa_pkg::HALF_W-1:0] <= csr_data;
            mpfa_pkg::REG_ONE_HI:
               cfg_ff.r_mod_p[mpfa_pkg::WORD_W-1:mpfa_pkg::HALF_W] <= csr_data;
            mpfa_pkg::REG_RSQ_LO: cfg_ff.r_squared[mpfa_pkg::HALF_W-1:0] <= csr_data;
            mpfa_pkg::REG_RSQ_HI:
               cfg_ff.r_squared[mpfa_pkg::WORD_W-1:mpfa_pkg::HALF_W] <= csr_data;
            default: ;
         endcase
      end
   end

endmodule

@@ rtl/mpfa_serial_mul.sv @@
// ----------------------------------------------------------------------------
// Bit-serial multiplier
// Full 256-bit product of two 128-bit values, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module mpfa_serial_mul (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [mpfa_pkg::WORD_W-1:0]  mul_x,
   input  logic [mpfa_pkg::WORD_W-1:0]  mul_y,
   output logic [mpfa_pkg::WORD_W-1:0]  prod_lo,
   output logic [mpfa_pkg::WORD_W-1:0]  prod_hi,
   output mpfa_pkg::mul_status_type     status
);

   localparam logic [mpfa_pkg::CNT_W-1:0] LastStep = mpfa_pkg::CNT_W'(mpfa_pkg::WORD_W - 1);

   logic                         busy_ff;
   logic                         done_ff;
   logic [mpfa_pkg::CNT_W-1:0]   cnt_ff;
   logic [mpfa_pkg::WORD_W-1:0]  hi_ff;
   logic [mpfa_pkg::WORD_W-1:0]  lo_ff;
   logic [mpfa_pkg::WORD_W-1:0]  mcand_ff;
   logic [mpfa_pkg::WORD_W:0]    sum_in;

   // The multiplier bit leaves the bottom of the low half as product bits enter its top.
   assign sum_in = {1'b0, hi_ff} + (lo_ff[0] ? {1'b0, mcand_ff} : '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= busy_ff && (cnt_ff == LastStep);
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == LastStep) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         hi_ff    <= '0;
         lo_ff    <= mul_y;
         mcand_ff <= mul_x;
      end else if (busy_ff) begin
         hi_ff <= sum_in[mpfa_pkg::WORD_W:1];
         lo_ff <= {sum_in[0], lo_ff[mpfa_pkg::WORD_W-1:1]};
      end
   end

   assign prod_lo     = lo_ff;
   assign prod_hi     = hi_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff) else $error("multiplier restarted while busy");
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff) else $error("done longer than one cycle");
   a_done_ends: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff) else $error("done while still busy");

endmodule

@@ rtl/montgomery_prime_field_alu_unit.sv @@
// ----------------------------------------------------------------------------
// Montgomery prime-field ALU
// 128-bit field arithmetic in Montgomery form (R = 2^128) with a bit-serial
// multiplier shared by multiply, conversions, inverse and Legendre test.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake            Carries
//   req_     in         req_valid/req_stall  operation, operand a, operand b
//   rsp_     out        rsp_valid/rsp_stall  result, non-residue flag
//   csr_     in         csr_valid/csr_ready  register index, 64-bit data
//
// Add, subtract and negate pass through ST_PRE and ST_RED before the result is presented.
// A Montgomery product is up to three multiplier passes (start, 128 shift-add
// steps, hand-over) plus the final subtract: multiply and to_mont run all three,
// from_mont skips the first pass. Inverse and Legendre chain 128 to 256 such
// products, one per exponent bit plus one per set bit. Reset is synchronous
// and clears control and the configuration; req_stall is high from acceptance
// until the result is taken.
// ----------------------------------------------------------------------------
module montgomery_prime_field_alu_unit (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [2:0]                   req_operation,
   input  logic [mpfa_pkg::HALF_W-1:0]  req_a_low,
   input  logic [mpfa_pkg::HALF_W-1:0]  req_a_high,
   input  logic [mpfa_pkg::HALF_W-1:0]  req_b_low,
   input  logic [mpfa_pkg::HALF_W-1:0]  req_b_high,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [mpfa_pkg::HALF_W-1:0]  rsp_result_low,
   output logic [mpfa_pkg::HALF_W-1:0]  rsp_result_high,
   output logic                         rsp_non_residue,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [2:0]                   csr_index,
   input  logic [mpfa_pkg::HALF_W-1:0]  csr_data
);

   localparam int W = mpfa_pkg::WORD_W;

   mpfa_pkg::cfg_type         cfg;
   mpfa_pkg::mul_status_type  mul_st;
   mpfa_pkg::state_type       state_ff, state_in;

   logic [W-1:0]  mul_lo, mul_hi, mul_x, mul_y;
   logic          mul_start;
   logic          go_ff, go_in;
   logic          req_take;

   mpfa_pkg::op_type op_ff;
   logic [W-1:0]  a_ff, b_ff;
   logic [W-1:0]  opx_ff, opy_ff;
   logic [W-1:0]  tlo_ff, thi_ff, m_ff;
   logic [W-1:0]  pre_ff;
   logic [W-1:0]  exp_ff;
   logic [mpfa_pkg::CNT_W-1:0] ecnt_ff;
   logic          mulph_ff;
   logic [W-1:0]  res_ff;
   logic          flag_ff;
   logic          rsp_valid_ff;

   logic [W-1:0]  a_in, b_in;
   logic          is_pow;
   logic [W:0]    s1, s2, rd, dd;
   logic [W-1:0]  pre_val, red_val, d_val, minus_one, p_minus_two, p_minus_one;
   logic          last_bit;

   mpfa_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   mpfa_serial_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .mul_x   (mul_x),
      .mul_y   (mul_y),
      .prod_lo (mul_lo),
      .prod_hi (mul_hi),
      .status  (mul_st)
   );

   assign a_in     = {req_a_high, req_a_low};
   assign b_in     = {req_b_high, req_b_low};
   assign req_take = req_valid && !req_stall;
   assign is_pow   = (op_ff == mpfa_pkg::OP_INVERSE) || (op_ff == mpfa_pkg::OP_LEGENDRE);

   // Add, subtract and negate: first step (for add and subtract with the wrap
   // folded through Montgomery one), then one conditional subtract of the modulus.
   always_comb begin
      s1 = '0;
      s2 = '0;
      pre_val = '0;
      unique case (op_ff)
         mpfa_pkg::OP_ADD: begin
            s1 = {1'b0, a_ff} + {1'b0, b_ff};
            s2 = {1'b0, s1[W-1:0]} + {1'b0, cfg.r_mod_p};
            pre_val = s1[W] ? s2[W-1:0] : s1[W-1:0];
         end
         mpfa_pkg::OP_SUB: begin
            s1 = {1'b0, a_ff} - {1'b0, b_ff};
            s2 = {1'b0, s1[W-1:0]} - {1'b0, cfg.r_mod_p};
            pre_val = s1[W] ? s2[W-1:0] : s1[W-1:0];
         end
         default: begin
            s1 = {1'b0, cfg.modulus} - {1'b0, a_ff};
            pre_val = s1[W-1:0];
         end
      endcase
   end

   assign rd      = {1'b0, pre_ff} - {1'b0, cfg.modulus};
   assign red_val = rd[W] ? pre_ff : rd[W-1:0];

   // Final step of the reduction: high half of T less high half of m*p,
   // with the modulus added back on a borrow.
   assign dd    = {1'b0, thi_ff} - {1'b0, mul_hi};
   assign d_val = dd[W] ? (dd[W-1:0] + cfg.modulus) : dd[W-1:0];

   assign minus_one   = cfg.modulus - cfg.r_mod_p;
   assign p_minus_two = cfg.modulus - W'(2);
   assign p_minus_one = cfg.modulus - W'(1);
   assign last_bit    = (ecnt_ff == '0);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mpfa_pkg::ST_IDLE: begin
            if (req_take) begin
               unique case (mpfa_pkg::op_type'(req_operation))
                  mpfa_pkg::OP_ADD, mpfa_pkg::OP_SUB, mpfa_pkg::OP_NEG:
                     state_in = mpfa_pkg::ST_PRE;
                  mpfa_pkg::OP_FROM_MONT:
                     state_in = mpfa_pkg::ST_MM;
                  default:
                     state_in = mpfa_pkg::ST_MT;
               endcase
            end
         end
         mpfa_pkg::ST_PRE: state_in = mpfa_pkg::ST_RED;
         mpfa_pkg::ST_RED: state_in = mpfa_pkg::ST_OUT;
         mpfa_pkg::ST_MT: if (mul_st.done) state_in = mpfa_pkg::ST_MM;
         mpfa_pkg::ST_MM: if (mul_st.done) state_in = mpfa_pkg::ST_MP;
         mpfa_pkg::ST_MP: if (mul_st.done) state_in = mpfa_pkg::ST_MD;
         mpfa_pkg::ST_MD: begin
            priority if (!is_pow) state_in = mpfa_pkg::ST_OUT;
            else if (!mulph_ff && exp_ff[W-1]) state_in = mpfa_pkg::ST_MT;
            else if (last_bit) state_in = mpfa_pkg::ST_OUT;
            else state_in = mpfa_pkg::ST_MT;
         end
         mpfa_pkg::ST_OUT: if (!rsp_stall) state_in = mpfa_pkg::ST_IDLE;
         default: state_in = mpfa_pkg::ST_IDLE;
      endcase
   end

   // A multiplier pass is started by go_ff, which is registered and high in the same cycle a multiply state is entered.
   assign go_in = ((state_in == mpfa_pkg::ST_MT) || (state_in == mpfa_pkg::ST_MM) ||
                   (state_in == mpfa_pkg::ST_MP)) && (state_in != state_ff);

   // Outputs and multiplier operand selection.
   always_comb begin
      req_stall = (state_ff != mpfa_pkg::ST_IDLE);
      rsp_valid = rsp_valid_ff;
      mul_start = go_ff;
      unique case (state_ff)
         mpfa_pkg::ST_MM: begin
            mul_x = tlo_ff;
            mul_y = cfg.modulus_inv;
         end
         mpfa_pkg::ST_MP: begin
            mul_x = m_ff;
            mul_y = cfg.modulus;
         end
         default: begin
            mul_x = opx_ff;
            mul_y = opy_ff;
         end
      endcase
   end

   assign rsp_result_low  = res_ff[mpfa_pkg::HALF_W-1:0];
   assign rsp_result_high = res_ff[W-1:mpfa_pkg::HALF_W];
   assign rsp_non_residue = flag_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mpfa_pkg::ST_IDLE;
         go_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         go_ff        <= go_in;
         rsp_valid_ff <= (state_in == mpfa_pkg::ST_OUT);
      end
   end

   // Operand, ladder and result registers.
   always_ff @(posedge clock) begin
      unique case (state_ff)
         mpfa_pkg::ST_IDLE: begin
            if (req_take) begin
               op_ff    <= mpfa_pkg::op_type'(req_operation);
               a_ff     <= a_in;
               b_ff     <= b_in;
               tlo_ff   <= a_in;
               thi_ff   <= '0;
               mulph_ff <= 1'b0;
               ecnt_ff  <= mpfa_pkg::CNT_W'(W - 1);
               unique case (mpfa_pkg::op_type'(req_operation))
                  mpfa_pkg::OP_TO_MONT: begin
                     opx_ff <= a_in;
                     opy_ff <= cfg.r_squared;
                  end
                  mpfa_pkg::OP_INVERSE: begin
                     opx_ff <= cfg.r_mod_p;
                     opy_ff <= cfg.r_mod_p;
                     exp_ff <= p_minus_two;
                  end
                  mpfa_pkg::OP_LEGENDRE: begin
                     opx_ff <= cfg.r_mod_p;
                     opy_ff <= cfg.r_mod_p;
                     exp_ff <= {1'b0, p_minus_one[W-1:1]};
                  end
                  default: begin
                     opx_ff <= a_in;
                     opy_ff <= b_in;
                  end
               endcase
            end
         end
         mpfa_pkg::ST_PRE: pre_ff <= pre_val;
         mpfa_pkg::ST_RED: begin
            res_ff  <= red_val;
            flag_ff <= 1'b0;
         end
         mpfa_pkg::ST_MT: begin
            if (mul_st.done) begin
               tlo_ff <= mul_lo;
               thi_ff <= mul_hi;
            end
         end
         mpfa_pkg::ST_MM: if (mul_st.done) m_ff <= mul_lo;
         mpfa_pkg::ST_MD: begin
            priority if (is_pow && !mulph_ff && exp_ff[W-1]) begin
               opx_ff   <= d_val;
               opy_ff   <= a_ff;
               mulph_ff <= 1'b1;
            end else if (is_pow && !last_bit) begin
               opx_ff   <= d_val;
               opy_ff   <= d_val;
               mulph_ff <= 1'b0;
               ecnt_ff  <= ecnt_ff - 1'b1;
               exp_ff   <= {exp_ff[W-2:0], 1'b0};
            end else begin
               res_ff  <= d_val;
               flag_ff <= (op_ff == mpfa_pkg::OP_LEGENDRE) && (d_val == minus_one);
            end
         end
         default: ;
      endcase
   end

   a_rsp_in_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (state_ff == mpfa_pkg::ST_OUT)) else $error("response outside output state");
   a_take_busy: assert property (@(posedge clock) disable iff (reset)
      req_take |=> (state_ff != mpfa_pkg::ST_IDLE)) else $error("accepted transaction lost");
   a_rsp_drain: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall) |=> (state_ff == mpfa_pkg::ST_IDLE))
      else $error("response taken but block not idle");
   a_mul_free: assert property (@(posedge clock) disable iff (reset)
      go_ff |-> !mul_st.busy) else $error("multiplier pass started while busy");

endmodule

@@ dv/testbench.sv @@
// ----------------------------------------------------------------------------
// Montgomery prime-field ALU testbench
// Drives operations with random handshake gaps on both sides and checks every
// result against a built-in 128-bit field predictor or a directed-table value,
// over several settings from the all-zero reset state to all-ones registers.
// ----------------------------------------------------------------------------
module testbench;
   import mpfa_pkg::*;

   typedef logic [WORD_W-1:0] elem_type;

   // One field result as the block should deliver it.
   typedef struct {
      elem_type value;
      logic     flag;
   } field_result_type;

   // One row of the directed table. Where typed is set, the expected result
   // is the one written in the row; otherwise the predictor supplies it.
   typedef struct {
      bit               stage;
      op_type           op;
      elem_type         a;
      elem_type         b;
      bit               typed;
      field_result_type res;
   } stim_row_type;

   // The slowest transaction is a power ladder of up to 256 products; the
   // handful of them plus a few hundred short transactions with random gaps
   // stay far below this.
   localparam int CYCLE_LIMIT = 4000000;
   localparam elem_type ALL_ONES = '1;
   // The largest 128-bit prime, 2^128 - 159.
   localparam elem_type BIG_PRIME = ALL_ONES - elem_type'(158);

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_operation = '0;
   logic [63:0] req_a_low = '0, req_a_high = '0, req_b_low = '0, req_b_high = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [63:0] rsp_result_low, rsp_result_high;
   logic        rsp_non_residue;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [63:0] csr_data = '0;

   cfg_type          field_cfg;          // the registers as the block should hold them
   field_result_type pending_results[$];
   stim_row_type     stim_table[$];
   int unsigned      cycle_count = 0;
   int unsigned      mismatch_count = 0;
   int unsigned      checked_count = 0;
   int unsigned      setting_count = 0;
   bit               quiet = 1'b0;       // when set, neither side idles

   montgomery_prime_field_alu_unit dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_operation   (req_operation),
      .req_a_low       (req_a_low),
      .req_a_high      (req_a_high),
      .req_b_low       (req_b_low),
      .req_b_high      (req_b_high),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_result_low  (rsp_result_low),
      .rsp_result_high (rsp_result_high),
      .rsp_non_residue (rsp_non_residue),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d results outstanding",
                  cycle_count, pending_results.size());
         $display("FAILURE");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Field predictor
   // ------------------------------------------------------------------------

   // Final conditional subtract: take off the modulus unless that would borrow.
   function automatic elem_type cond_subtract(elem_type x);
      return (x >= field_cfg.modulus) ? x - field_cfg.modulus : x;
   endfunction

   // Montgomery reduction in its subtracting form: with m = T * p^-1 the low
   // halves of T and m * p cancel, so only the high halves are subtracted.
   function automatic elem_type mont_reduce(logic [2*WORD_W-1:0] t);
      logic [2*WORD_W-1:0] w;
      logic [2*WORD_W-1:0] mp;
      elem_type            d;
      w  = {elem_type'(0), t[WORD_W-1:0]} * {elem_type'(0), field_cfg.modulus_inv};
      mp = {elem_type'(0), w[WORD_W-1:0]} * {elem_type'(0), field_cfg.modulus};
      d  = t[2*WORD_W-1:WORD_W] - mp[2*WORD_W-1:WORD_W];
      if (t[2*WORD_W-1:WORD_W] < mp[2*WORD_W-1:WORD_W])
         d = d + field_cfg.modulus;
      return d;
   endfunction

   function automatic elem_type mont_product(elem_type x, elem_type y);
      return mont_reduce({elem_type'(0), x} * {elem_type'(0), y});
   endfunction

   // Square-and-multiply over all 128 exponent bits, starting from one.
   function automatic elem_type field_power(elem_type base, elem_type e);
      elem_type t;
      t = field_cfg.r_mod_p;
      for (int i = WORD_W - 1; i >= 0; i--) begin
         t = mont_product(t, t);
         if (e[i])
            t = mont_product(t, base);
      end
      return t;
   endfunction

   function automatic field_result_type field_predict(op_type op, elem_type a, elem_type b);
      field_result_type r;
      logic [WORD_W:0]  wide;
      elem_type         s;
      r.flag = 1'b0;
      case (op)
         OP_ADD: begin
            wide = {1'b0, a} + {1'b0, b};
            s = wide[WORD_W-1:0];
            if (wide[WORD_W])
               s = s + field_cfg.r_mod_p;
            r.value = cond_subtract(s);
         end
         OP_SUB: begin
            s = a - b;
            if (a < b)
               s = s - field_cfg.r_mod_p;
            r.value = cond_subtract(s);
         end
         OP_NEG:       r.value = cond_subtract(field_cfg.modulus - a);
         OP_MUL:       r.value = mont_product(a, b);
         OP_TO_MONT:   r.value = mont_product(a, field_cfg.r_squared);
         OP_FROM_MONT: r.value = mont_reduce({elem_type'(0), a});
         OP_INVERSE:   r.value = field_power(a, field_cfg.modulus - elem_type'(2));
         default: begin
            r.value = field_power(a, (field_cfg.modulus - elem_type'(1)) >> 1);
            r.flag  = (r.value == field_cfg.modulus - field_cfg.r_mod_p);
         end
      endcase
      return r;
   endfunction

   // Consistent register set for a modulus: R mod p, R^2 mod p, and p^-1 by
   // Newton iteration (an odd p is its own inverse to three bits).
   function automatic cfg_type derive_setting(elem_type p);
      cfg_type             c;
      logic [2*WORD_W+3:0] big;
      elem_type            x;
      c.modulus = p;
      big = '0;
      big[WORD_W] = 1'b1;
      c.r_mod_p = elem_type'(big % p);
      big = '0;
      big[2*WORD_W] = 1'b1;
      c.r_squared = elem_type'(big % p);
      x = p;
      repeat (7) x = x * (elem_type'(2) - p * x);
      c.modulus_inv = x;
      return c;
   endfunction

   function automatic elem_type random_elem();
      return {$urandom, $urandom, $urandom, $urandom};
   endfunction

   // Mostly reduced operands, with raw words and edge values mixed in.
   function automatic elem_type random_operand();
      int unsigned pick;
      pick = $urandom_range(0, 19);
      if (pick < 14 && field_cfg.modulus != 0)
         return random_elem() % field_cfg.modulus;
      else if (pick < 16)
         return random_elem();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return elem_type'(1);
         2:       return field_cfg.modulus - elem_type'(1);
         3:       return field_cfg.modulus;
         4:       return field_cfg.r_mod_p;
         default: return ALL_ONES;
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // Handshake tasks
   // ------------------------------------------------------------------------

   task automatic report_mismatch(string what, logic [WORD_W-1:0] got, logic [WORD_W-1:0] want);
      $display("Mismatch on %s at cycle %0d: got %h, expected %h",
               what, cycle_count, got, want);
      mismatch_count++;
   endtask

   task automatic wait_idle();
      while (pending_results.size() != 0)
         @(posedge clock);
   endtask

   // Valid stays high between consecutive writes; load_setting lowers it.
   task automatic write_register(reg_idx_type idx, logic [HALF_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_MOD_LO: field_cfg.modulus[HALF_W-1:0]          = data;
         REG_MOD_HI: field_cfg.modulus[WORD_W-1:HALF_W]     = data;
         REG_INV_LO: field_cfg.modulus_inv[HALF_W-1:0]      = data;
         REG_INV_HI: field_cfg.modulus_inv[WORD_W-1:HALF_W] = data;
         REG_ONE_LO: field_cfg.r_mod_p[HALF_W-1:0]          = data;
         REG_ONE_HI: field_cfg.r_mod_p[WORD_W-1:HALF_W]     = data;
         REG_RSQ_LO: field_cfg.r_squared[HALF_W-1:0]        = data;
         REG_RSQ_HI: field_cfg.r_squared[WORD_W-1:HALF_W]   = data;
      endcase
   endtask

   // Loads a full register set once the block has drained.
   // The request valid is dropped first so the last transaction is not taken
   // a second time once the block returns to idle.
   task automatic load_setting(cfg_type c);
      req_valid <= 1'b0;
      wait_idle();
      repeat (4) @(posedge clock);
      write_register(REG_MOD_LO, c.modulus[HALF_W-1:0]);
      write_register(REG_MOD_HI, c.modulus[WORD_W-1:HALF_W]);
      write_register(REG_INV_LO, c.modulus_inv[HALF_W-1:0]);
      write_register(REG_INV_HI, c.modulus_inv[WORD_W-1:HALF_W]);
      write_register(REG_ONE_LO, c.r_mod_p[HALF_W-1:0]);
      write_register(REG_ONE_HI, c.r_mod_p[WORD_W-1:HALF_W]);
      write_register(REG_RSQ_LO, c.r_squared[HALF_W-1:0]);
      write_register(REG_RSQ_HI, c.r_squared[WORD_W-1:HALF_W]);
      csr_valid <= 1'b0;
      setting_count++;
   endtask

   // Presents one transaction after a random gap and records its expected
   // result at the edge where it is taken. Valid is only lowered when a gap
   // follows, so back-to-back transactions keep it high.
   task automatic send_op(op_type op, elem_type a, elem_type b, bit typed,
                          field_result_type res);
      int unsigned gap;
      gap = quiet ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_operation <= op;
      req_a_low     <= a[HALF_W-1:0];
      req_a_high    <= a[WORD_W-1:HALF_W];
      req_b_low     <= b[HALF_W-1:0];
      req_b_high    <= b[WORD_W-1:HALF_W];
      do @(posedge clock); while (req_stall);
      pending_results.push_back(typed ? res : field_predict(op, a, b));
   endtask

   // Leaves valid as it is at the end; a later load, or a send after a gap, lowers it.
   task automatic random_phase(int unsigned count);
      op_type           op;
      field_result_type none;
      none = '{value: '0, flag: 1'b0};
      for (int unsigned i = 0; i < count; i++) begin
         // Power ladders cost 128 to 256 products, so they stay rare.
         if ($urandom_range(0, 99) == 0)
            op = op_type'($urandom_range(OP_INVERSE, OP_LEGENDRE));
         else
            op = op_type'($urandom_range(OP_ADD, OP_FROM_MONT));
         send_op(op, random_operand(), random_operand(), 1'b0, none);
      end
   endtask

   // ------------------------------------------------------------------------
   // Result side: stall for a random number of cycles, then take a transaction
   // and compare it field by field with the oldest expectation.
   // ------------------------------------------------------------------------
   initial begin : result_side
      int unsigned      hold;
      field_result_type want;
      @(negedge reset);
      forever begin
         hold = quiet ? 0 : $urandom_range(0, 18);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (!rsp_valid);
         if (pending_results.size() == 0) begin
            $display("Unexpected result transaction at cycle %0d", cycle_count);
            mismatch_count++;
         end else begin
            want = pending_results.pop_front();
            checked_count++;
            if (rsp_result_low !== want.value[HALF_W-1:0])
               report_mismatch("result_low", rsp_result_low, want.value[HALF_W-1:0]);
            if (rsp_result_high !== want.value[WORD_W-1:HALF_W])
               report_mismatch("result_high", rsp_result_high, want.value[WORD_W-1:HALF_W]);
            if (rsp_non_residue !== want.flag)
               report_mismatch("non_residue", rsp_non_residue, want.flag);
         end
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------
   initial begin : stimulus
      cfg_type     setting;
      elem_type    p1;
      bit          stage;
      elem_type    odd_p;

      field_cfg = '0;
      p1 = BIG_PRIME;

      // Stage 0 runs on the all-zero reset registers, where every product
      // collapses to the high half of the plain product and the answers can
      // be written down directly. The Legendre test there exercises the
      // wrapped exponent and reports a non-residue, since p - one is zero.
      stim_table.push_back('{0, OP_ADD, elem_type'(5), elem_type'(7), 1, '{elem_type'(12), 0}});
      stim_table.push_back('{0, OP_ADD, ALL_ONES, elem_type'(1), 1, '{elem_type'(0), 0}});
      stim_table.push_back('{0, OP_SUB, elem_type'(7), elem_type'(5), 1, '{elem_type'(2), 0}});
      stim_table.push_back('{0, OP_MUL, elem_type'(1) << 127, elem_type'(4), 1,
                             '{elem_type'(2), 0}});
      stim_table.push_back('{0, OP_LEGENDRE, elem_type'(3), ALL_ONES, 1, '{elem_type'(0), 1}});
      // Stage 1 uses the largest 128-bit prime with a consistent register set.
      stim_table.push_back('{1, OP_NEG, elem_type'(0), elem_type'(0), 1, '{elem_type'(0), 0}});
      stim_table.push_back('{1, OP_NEG, elem_type'(1), ALL_ONES, 1, '{p1 - 1, 0}});
      stim_table.push_back('{1, OP_NEG, ALL_ONES, elem_type'(0), 0, '{0, 0}});
      stim_table.push_back('{1, OP_ADD, p1 - 1, elem_type'(1), 1, '{elem_type'(0), 0}});
      stim_table.push_back('{1, OP_ADD, p1 - 1, p1 - 1, 0, '{0, 0}});
      stim_table.push_back('{1, OP_ADD, ALL_ONES, ALL_ONES, 0, '{0, 0}});
      stim_table.push_back('{1, OP_SUB, elem_type'(5), elem_type'(5), 1, '{elem_type'(0), 0}});
      stim_table.push_back('{1, OP_SUB, elem_type'(0), elem_type'(1), 0, '{0, 0}});
      stim_table.push_back('{1, OP_SUB, elem_type'(0), ALL_ONES, 0, '{0, 0}});
      stim_table.push_back('{1, OP_MUL, elem_type'(0), ALL_ONES, 1, '{elem_type'(0), 0}});
      stim_table.push_back('{1, OP_MUL, ALL_ONES, ALL_ONES, 0, '{0, 0}});
      stim_table.push_back('{1, OP_MUL, p1 - 1, p1 - 1, 0, '{0, 0}});
      stim_table.push_back('{1, OP_TO_MONT, elem_type'(1), ALL_ONES, 0, '{0, 0}});
      stim_table.push_back('{1, OP_TO_MONT, ALL_ONES, elem_type'(0), 0, '{0, 0}});
      stim_table.push_back('{1, OP_FROM_MONT, elem_type'(0), ALL_ONES, 1,
                             '{elem_type'(0), 0}});
      stim_table.push_back('{1, OP_FROM_MONT, p1 - 1, elem_type'(0), 0, '{0, 0}});
      stim_table.push_back('{1, OP_INVERSE, elem_type'(2), ALL_ONES, 0, '{0, 0}});
      stim_table.push_back('{1, OP_LEGENDRE, p1 - 1, elem_type'(0), 0, '{0, 0}});

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      stage = 1'b0;
      foreach (stim_table[i]) begin
         if (stim_table[i].stage != stage) begin
            stage = stim_table[i].stage;
            load_setting(derive_setting(p1));
         end
         send_op(stim_table[i].op, stim_table[i].a, stim_table[i].b,
                 stim_table[i].typed, stim_table[i].res);
      end

      // Random phases, one or two on each register setting.
      random_phase(45);

      odd_p = random_elem();
      odd_p[WORD_W-1] = 1'b1;
      odd_p[0] = 1'b1;
      load_setting(derive_setting(odd_p));
      quiet = 1'b1;
      random_phase(45);
      quiet = 1'b0;
      random_phase(45);

      // Smallest odd modulus with the top bit set.
      load_setting(derive_setting((elem_type'(1) << 127) + elem_type'(1)));
      random_phase(45);

      // Registers at their upper extreme, then unrelated random values.
      setting = '{modulus: ALL_ONES, modulus_inv: ALL_ONES,
                  r_mod_p: ALL_ONES, r_squared: ALL_ONES};
      load_setting(setting);
      random_phase(45);

      setting = '{modulus: random_elem(), modulus_inv: random_elem(),
                  r_mod_p: random_elem(), r_squared: random_elem()};
      load_setting(setting);
      random_phase(45);

      req_valid <= 1'b0;
      wait_idle();
      repeat (50) @(posedge clock);

      $display("Checked %0d result transactions over %0d register settings;",
               checked_count, setting_count + 1);
      $display("all eight operations ran with idle gaps on both channels.");
      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("FAILURE");
      end
      $finish;
   end

endmodule

@@ montgomery_prime_field_alu_unit.f @@
rtl/mpfa_pkg.sv
rtl/mpfa_csr.sv
rtl/mpfa_serial_mul.sv
rtl/montgomery_prime_field_alu_unit.sv
dv/testbench.sv
